@@ sv/dsc_pkg.sv @@
// Package for the display scaler setup block: write targets, coefficient
// tables and the record that travels beside the ratio dividers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int TGT_W  = 4;
  localparam int WORD_W = 32;
  localparam int COEF_N = 8;
  localparam int AREA_W = 2 * DIM_W;

  localparam logic [TGT_W-1:0] TGT_HRATIO = 4'd0;
  localparam logic [TGT_W-1:0] TGT_VRATIO = 4'd1;
  localparam logic [TGT_W-1:0] TGT_COEF0  = 4'd2;
  localparam logic [TGT_W-1:0] TGT_LAYER  = 4'd10;
  localparam logic [TGT_W-1:0] TGT_ISIZE  = 4'd11;
  localparam logic [TGT_W-1:0] TGT_OSIZE  = 4'd12;
  localparam logic [TGT_W-1:0] TGT_CROP   = 4'd13;
  localparam logic [TGT_W-1:0] TGT_POS    = 4'd14;

  typedef enum logic [1:0] {
    COEF_SHARP,
    COEF_MID,
    COEF_SOFT
  } dsc_coef_sel_t;

  typedef struct packed {
    dsc_coef_sel_t    sel;
    logic [POS_W-1:0] sw_m1;
    logic [POS_W-1:0] sh_m1;
    logic [POS_W-1:0] dw_m1;
    logic [POS_W-1:0] dh_m1;
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
  } dsc_side_t;

  localparam logic [WORD_W-1:0] COEF_SHARP_TBL [COEF_N] = '{
    32'h0000_4000, 32'hFF07_3EFC, 32'hFE10_38FA, 32'hFC1B_30F9,
    32'hFA26_26FA, 32'hF930_1BFC, 32'hFA38_10FE, 32'hFC3E_07FF
  };
  localparam logic [WORD_W-1:0] COEF_MID_TBL [COEF_N] = '{
    32'h0000_4000, 32'h0008_3800, 32'h0010_3000, 32'h0018_2800,
    32'h0020_2000, 32'h0028_1800, 32'h0030_1000, 32'h0038_0800
  };
  localparam logic [WORD_W-1:0] COEF_SOFT_TBL [COEF_N] = '{
    32'h0010_2010, 32'h0212_1E0E, 32'h0414_1C0C, 32'h0616_1A0A,
    32'h0818_1808, 32'h0A1A_1606, 32'h0C1C_1404, 32'h0E1E_1202
  };

  function automatic logic [WORD_W-1:0] coef_word(input dsc_coef_sel_t sel,
                                                  input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    unique case (sel)
      COEF_SHARP: w = COEF_SHARP_TBL[idx];
      COEF_MID:   w = COEF_MID_TBL[idx];
      default:    w = COEF_SOFT_TBL[idx];
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/dsc_prep.sv @@
// Front stages: clamp dimensions, form area products and ratio dividends,
// pick the coefficient set. Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsc_prep #(
  parameter int SCALE_ONE = 8192,
  parameter int MAX_DIM   = 4096,
  parameter int NUM_W     = 26
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          adv,
  input  wire                          in_vld,
  input  wire  [dsc_pkg::DIM_W-1:0]    src_width,
  input  wire  [dsc_pkg::DIM_W-1:0]    src_height,
  input  wire  [dsc_pkg::POS_W-1:0]    dst_xpos,
  input  wire  [dsc_pkg::POS_W-1:0]    dst_ypos,
  input  wire  [dsc_pkg::DIM_W-1:0]    dst_width,
  input  wire  [dsc_pkg::DIM_W-1:0]    dst_height,
  output logic                         out_vld,
  output logic [NUM_W-1:0]             num_h,
  output logic [NUM_W-1:0]             num_v,
  output logic [dsc_pkg::DIM_W-1:0]    den_h,
  output logic [dsc_pkg::DIM_W-1:0]    den_v,
  output dsc_pkg::dsc_side_t           side
);
  import dsc_pkg::*;

  localparam int CMP_W = AREA_W + 5;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                v1_r, v2_r, v3_r;
  logic [DIM_W-1:0]    sw1_r, sh1_r, dw1_r, dh1_r;
  logic [POS_W-1:0]    dx1_r, dy1_r;
  logic [AREA_W-1:0]   as2_r, ad2_r;
  logic [NUM_W-1:0]    nh2_r, nv2_r, nh3_r, nv3_r;
  logic [DIM_W-1:0]    dw2_r, dh2_r, dw3_r, dh3_r;
  dsc_side_t           side2_r, side3_r;
  dsc_side_t           side3_nxt;
  logic [CMP_W-1:0]    ten_a, b11, b21;
  dsc_coef_sel_t       sel_nxt;

  always_comb begin
    ten_a = (CMP_W'(as2_r) << 3) + (CMP_W'(as2_r) << 1);
    b11   = (CMP_W'(ad2_r) << 3) + (CMP_W'(ad2_r) << 1) + CMP_W'(ad2_r);
    b21   = (CMP_W'(ad2_r) << 4) + (CMP_W'(ad2_r) << 2) + CMP_W'(ad2_r);
    priority if (ten_a < b11) begin
      sel_nxt = COEF_SHARP;
    end else if (ten_a < b21) begin
      sel_nxt = COEF_MID;
    end else begin
      sel_nxt = COEF_SOFT;
    end
    side3_nxt     = side2_r;
    side3_nxt.sel = sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sw1_r <= clamp_dim(src_width);
      sh1_r <= clamp_dim(src_height);
      dw1_r <= clamp_dim(dst_width);
      dh1_r <= clamp_dim(dst_height);
      dx1_r <= dst_xpos;
      dy1_r <= dst_ypos;

      as2_r <= AREA_W'(sw1_r) * AREA_W'(sh1_r);
      ad2_r <= AREA_W'(dw1_r) * AREA_W'(dh1_r);
      nh2_r <= NUM_W'(sw1_r) * NUM_W'(SCALE_ONE) + NUM_W'(dw1_r) - NUM_W'(1);
      nv2_r <= NUM_W'(sh1_r) * NUM_W'(SCALE_ONE) + NUM_W'(dh1_r) - NUM_W'(1);
      dw2_r <= dw1_r;
      dh2_r <= dh1_r;
      side2_r.sel   <= COEF_SHARP;
      side2_r.sw_m1 <= POS_W'(sw1_r - DIM_W'(1));
      side2_r.sh_m1 <= POS_W'(sh1_r - DIM_W'(1));
      side2_r.dw_m1 <= POS_W'(dw1_r - DIM_W'(1));
      side2_r.dh_m1 <= POS_W'(dh1_r - DIM_W'(1));
      side2_r.dx    <= dx1_r;
      side2_r.dy    <= dy1_r;

      nh3_r   <= nh2_r;
      nv3_r   <= nv2_r;
      dw3_r   <= dw2_r;
      dh3_r   <= dh2_r;
      side3_r <= side3_nxt;
    end
  end

  assign out_vld = v3_r;
  assign num_h   = nh3_r;
  assign num_v   = nv3_r;
  assign den_h   = dw3_r;
  assign den_v   = dh3_r;
  assign side    = side3_r;

endmodule

`default_nettype wire

@@ sv/dsc_div.sv @@
// Pipelined restoring dividers for the horizontal and vertical ratios,
// up to STEP_N quotient bits per stage, with the request record alongside.
// Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsc_div #(
  parameter int NUM_W  = 26,
  parameter int STEP_N = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          adv,
  input  wire                          in_vld,
  input  wire  [NUM_W-1:0]             num_h,
  input  wire  [NUM_W-1:0]             num_v,
  input  wire  [dsc_pkg::DIM_W-1:0]    den_h,
  input  wire  [dsc_pkg::DIM_W-1:0]    den_v,
  input  dsc_pkg::dsc_side_t           side_in,
  output logic                         out_vld,
  output logic [NUM_W-1:0]             quo_h,
  output logic [NUM_W-1:0]             quo_v,
  output dsc_pkg::dsc_side_t           side_out
);
  import dsc_pkg::*;

  localparam int STG_N = (NUM_W + STEP_N - 1) / STEP_N;

  function automatic logic [DIM_W+NUM_W-1:0] div_steps(
    input logic [DIM_W-1:0] rem,
    input logic [NUM_W-1:0] nq,
    input logic [DIM_W-1:0] den,
    input int               base
  );
    logic [DIM_W:0]   t;
    logic [DIM_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = rem;
    q = nq;
    for (int j = 0; j < STEP_N; j++) begin
      if (base + j < NUM_W) begin
        t = {r, q[NUM_W-1]};
        q = q << 1;
        if (t >= {1'b0, den}) begin
          r    = DIM_W'(t - {1'b0, den});
          q[0] = 1'b1;
        end else begin
          r = t[DIM_W-1:0];
        end
      end
    end
    return {r, q};
  endfunction

  logic             vld_r  [STG_N];
  logic [DIM_W-1:0] rh_r   [STG_N];
  logic [DIM_W-1:0] rv_r   [STG_N];
  logic [NUM_W-1:0] qh_r   [STG_N];
  logic [NUM_W-1:0] qv_r   [STG_N];
  logic [DIM_W-1:0] dh_r   [STG_N];
  logic [DIM_W-1:0] dv_r   [STG_N];
  dsc_side_t        side_r [STG_N];

  for (genvar s = 0; s < STG_N; s++) begin : g_stg
    logic             vld_i;
    logic [DIM_W-1:0] rh_i, rv_i, dh_i, dv_i;
    logic [NUM_W-1:0] qh_i, qv_i;
    dsc_side_t        side_i;
    logic [DIM_W+NUM_W-1:0] h_nxt, v_nxt;

    if (s == 0) begin : g_head
      assign vld_i  = in_vld;
      assign rh_i   = '0;
      assign rv_i   = '0;
      assign qh_i   = num_h;
      assign qv_i   = num_v;
      assign dh_i   = den_h;
      assign dv_i   = den_v;
      assign side_i = side_in;
    end else begin : g_body
      assign vld_i  = vld_r[s-1];
      assign rh_i   = rh_r[s-1];
      assign rv_i   = rv_r[s-1];
      assign qh_i   = qh_r[s-1];
      assign qv_i   = qv_r[s-1];
      assign dh_i   = dh_r[s-1];
      assign dv_i   = dv_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign h_nxt = div_steps(rh_i, qh_i, dh_i, s * STEP_N);
    assign v_nxt = div_steps(rv_i, qv_i, dv_i, s * STEP_N);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rh_r[s]   <= h_nxt[DIM_W+NUM_W-1:NUM_W];
        qh_r[s]   <= h_nxt[NUM_W-1:0];
        rv_r[s]   <= v_nxt[DIM_W+NUM_W-1:NUM_W];
        qv_r[s]   <= v_nxt[NUM_W-1:0];
        dh_r[s]   <= dh_i;
        dv_r[s]   <= dv_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[STG_N-1];
  assign quo_h    = qh_r[STG_N-1];
  assign quo_v    = qv_r[STG_N-1];
  assign side_out = side_r[STG_N-1];

endmodule

`default_nettype wire

@@ sv/dsc_emit.sv @@
// Write sequencer: holds one finished request and plays out its fifteen
// register write beats in target order. Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsc_emit #(
  parameter int NUM_W = 26
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_vld,
  output logic                          in_rdy,
  input  wire  [NUM_W-1:0]              quo_h,
  input  wire  [NUM_W-1:0]              quo_v,
  input  dsc_pkg::dsc_side_t            side,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [dsc_pkg::TGT_W-1:0]     out_target,
  output logic [dsc_pkg::WORD_W-1:0]    out_value,
  output logic                          out_last
);
  import dsc_pkg::*;

  logic              ev_r;
  logic [TGT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  hr_r, vr_r;
  dsc_side_t         rec_r;
  logic              beat_done;
  logic              end_beat;
  logic              load;

  assign end_beat  = (cnt_r == TGT_POS);
  assign beat_done = ev_r && !out_stall;
  assign in_rdy    = !ev_r || (beat_done && end_beat);
  assign load      = in_vld && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r  <= 1'b0;
      cnt_r <= TGT_HRATIO;
    end else if (load) begin
      ev_r  <= 1'b1;
      cnt_r <= TGT_HRATIO;
    end else if (beat_done) begin
      if (end_beat) begin
        ev_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + TGT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hr_r  <= quo_h;
      vr_r  <= quo_v;
      rec_r <= side;
    end
  end

  always_comb begin
    unique case (cnt_r)
      TGT_HRATIO: out_value = WORD_W'(hr_r);
      TGT_VRATIO: out_value = WORD_W'(vr_r);
      TGT_LAYER:  out_value = '0;
      TGT_ISIZE:  out_value = {4'd0, rec_r.sh_m1, 4'd0, rec_r.sw_m1};
      TGT_OSIZE:  out_value = {4'd0, rec_r.dh_m1, 4'd0, rec_r.dw_m1};
      TGT_CROP:   out_value = {4'd0, rec_r.dh_m1, 4'd0, rec_r.dw_m1};
      TGT_POS:    out_value = {4'd0, rec_r.dy, 4'd0, rec_r.dx};
      default:    out_value = coef_word(rec_r.sel, 3'(cnt_r - TGT_COEF0));
    endcase
  end

  assign out_valid  = ev_r;
  assign out_target = cnt_r;
  assign out_last   = end_beat;

endmodule

`default_nettype wire

@@ sv/display_scaler_setup.sv @@
// Display scaler setup, top level: prep stages, ratio dividers and the
// write sequencer. Depends on dsc_pkg, dsc_prep, dsc_div and dsc_emit.
//
// Each accepted request produces fifteen write beats on the out_ channel,
// targets 0 through 14 in order, out_last on the position write. The
// request goes through three front stages (clamp, products, coefficient
// set compare) and ceil(NUM_W/4) divider stages, seven at the default
// parameters, then the sequencer: with the sequencer idle, out_valid rises
// once the sequencer's register has loaded the request from the last divider
// stage. The sequencer plays one beat per cycle while out_stall is low and
// takes no new request until the last beat of the one it holds; the pipeline
// keeps taking requests until a request reaches the divider end behind a
// busy sequencer, which stalls every stage, and a request held at the pipeline
// end moves in on the same cycle as the last beat of the one before.
`timescale 1ns / 1ps
`default_nettype none

module display_scaler_setup #(
  parameter int SCALE_ONE = 8192,
  parameter int MAX_DIM   = 4096
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [dsc_pkg::DIM_W-1:0]    in_src_width,
  input  wire  [dsc_pkg::DIM_W-1:0]    in_src_height,
  input  wire  [dsc_pkg::POS_W-1:0]    in_dst_xpos,
  input  wire  [dsc_pkg::POS_W-1:0]    in_dst_ypos,
  input  wire  [dsc_pkg::DIM_W-1:0]    in_dst_width,
  input  wire  [dsc_pkg::DIM_W-1:0]    in_dst_height,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [dsc_pkg::TGT_W-1:0]    out_target,
  output logic [dsc_pkg::WORD_W-1:0]   out_value,
  output logic                         out_last
);
  import dsc_pkg::*;

  localparam int NUM_W = $clog2(MAX_DIM * (SCALE_ONE + 1));

  logic             adv;
  logic             prep_vld, div_vld, emit_rdy;
  logic [NUM_W-1:0] num_h, num_v, quo_h, quo_v;
  logic [DIM_W-1:0] den_h, den_v;
  dsc_side_t        prep_side, div_side;

  assign adv      = !div_vld || emit_rdy;
  assign in_stall = !adv;

  dsc_prep #(
    .SCALE_ONE (SCALE_ONE),
    .MAX_DIM   (MAX_DIM),
    .NUM_W     (NUM_W)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_valid),
    .src_width  (in_src_width),
    .src_height (in_src_height),
    .dst_xpos   (in_dst_xpos),
    .dst_ypos   (in_dst_ypos),
    .dst_width  (in_dst_width),
    .dst_height (in_dst_height),
    .out_vld    (prep_vld),
    .num_h      (num_h),
    .num_v      (num_v),
    .den_h      (den_h),
    .den_v      (den_v),
    .side       (prep_side)
  );

  dsc_div #(
    .NUM_W  (NUM_W),
    .STEP_N (4)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (prep_vld),
    .num_h    (num_h),
    .num_v    (num_v),
    .den_h    (den_h),
    .den_v    (den_v),
    .side_in  (prep_side),
    .out_vld  (div_vld),
    .quo_h    (quo_h),
    .quo_v    (quo_v),
    .side_out (div_side)
  );

  dsc_emit #(
    .NUM_W (NUM_W)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (div_vld),
    .in_rdy     (emit_rdy),
    .quo_h      (quo_h),
    .quo_v      (quo_v),
    .side       (div_side),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_target (out_target),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for display_scaler_setup: drives scaling requests,
// predicts the fifteen scaler writes of each and checks every out_ beat.
// Depends on dsc_pkg and display_scaler_setup.
`timescale 1ns / 1ps

module tb_top;
  import dsc_pkg::*;

  localparam int SCALE_ONE      = 8192;
  localparam int MAX_DIM        = 4096;
  localparam int WRITES_PER_REQ = 15;
  localparam int RANDOM_REQS    = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HOLD_AT_BEAT   = 480;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_PRINTS     = 100;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [POS_W-1:0] dst_xpos;
    logic [POS_W-1:0] dst_ypos;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } scale_req_t;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [WORD_W-1:0] value;
    logic              last;
  } write_beat_t;

  class scaler_write_board;
    write_beat_t pending_writes[$];
    int errors = 0;
    int requests = 0;
    int writes_checked = 0;

    task report(string what);
      if (errors < MAX_PRINTS) $display("mismatch: %s", what);
      errors++;
    endtask

    function longint unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void add_write(logic [TGT_W-1:0] target, logic [WORD_W-1:0] value, logic last);
      write_beat_t w;
      w.target = target;
      w.value  = value;
      w.last   = last;
      pending_writes.push_back(w);
    endfunction

    function void note_request(scale_req_t r);
      longint unsigned sw, sh, dw, dh, area_factor, hratio, vratio;
      dsc_coef_sel_t sel;
      logic [WORD_W-1:0] coef, osize;
      sw = clamp_dim(r.src_width);
      sh = clamp_dim(r.src_height);
      dw = clamp_dim(r.dst_width);
      dh = clamp_dim(r.dst_height);
      area_factor = (sw * sh * 10) / (dw * dh);
      hratio = (sw * SCALE_ONE + dw - 1) / dw;
      vratio = (sh * SCALE_ONE + dh - 1) / dh;
      if (area_factor <= 10) sel = COEF_SHARP;
      else if (area_factor <= 20) sel = COEF_MID;
      else sel = COEF_SOFT;
      add_write(TGT_HRATIO, hratio[WORD_W-1:0], 1'b0);
      add_write(TGT_VRATIO, vratio[WORD_W-1:0], 1'b0);
      for (int i = 0; i < COEF_N; i++) begin
        case (sel)
          COEF_SHARP: coef = COEF_SHARP_TBL[i];
          COEF_MID:   coef = COEF_MID_TBL[i];
          default:    coef = COEF_SOFT_TBL[i];
        endcase
        add_write(TGT_W'(TGT_COEF0 + i), coef, 1'b0);
      end
      add_write(TGT_LAYER, '0, 1'b0);
      add_write(TGT_ISIZE, {4'd0, sh[11:0] - 12'd1, 4'd0, sw[11:0] - 12'd1}, 1'b0);
      osize = {4'd0, dh[11:0] - 12'd1, 4'd0, dw[11:0] - 12'd1};
      add_write(TGT_OSIZE, osize, 1'b0);
      add_write(TGT_CROP, osize, 1'b0);
      add_write(TGT_POS, {4'd0, r.dst_ypos, 4'd0, r.dst_xpos}, 1'b1);
      requests++;
    endfunction

    task check_write(logic [TGT_W-1:0] target, logic [WORD_W-1:0] value, logic last);
      write_beat_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("write to target %0d value %h with no request pending", target, value));
        return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      if (target !== want.target)
        report($sformatf("target %0d, want %0d", target, want.target));
      if (value !== want.value)
        report($sformatf("target %0d value %h, want %h", want.target, value, want.value));
      if (last !== want.last)
        report($sformatf("target %0d last %b, want %b", want.target, last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [DIM_W-1:0] in_src_width;
  logic [DIM_W-1:0] in_src_height;
  logic [POS_W-1:0] in_dst_xpos;
  logic [POS_W-1:0] in_dst_ypos;
  logic [DIM_W-1:0] in_dst_width;
  logic [DIM_W-1:0] in_dst_height;
  logic out_valid;
  logic out_stall;
  logic [TGT_W-1:0] out_target;
  logic [WORD_W-1:0] out_value;
  logic out_last;

  scaler_write_board board = new();
  int idle_cycles = 0;
  int sent = 0;
  int sink_beats = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  always #1 clk = ~clk;

  display_scaler_setup #(
    .SCALE_ONE(SCALE_ONE),
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_src_width(in_src_width),
    .in_src_height(in_src_height),
    .in_dst_xpos(in_dst_xpos),
    .in_dst_ypos(in_dst_ypos),
    .in_dst_width(in_dst_width),
    .in_dst_height(in_dst_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_target(out_target),
    .out_value(out_value),
    .out_last(out_last)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task send_request(input int sw, input int sh, input int dx, input int dy,
                    input int dw, input int dh);
    scale_req_t r;
    int gap;
    r.src_width  = DIM_W'(sw);
    r.src_height = DIM_W'(sh);
    r.dst_xpos   = POS_W'(dx);
    r.dst_ypos   = POS_W'(dy);
    r.dst_width  = DIM_W'(dw);
    r.dst_height = DIM_W'(dh);
    if (sent % 12 == 0) src_quiet = ($urandom_range(0, 3) == 0);
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_src_width  = r.src_width;
    in_src_height = r.src_height;
    in_dst_xpos   = r.dst_xpos;
    in_dst_ypos   = r.dst_ypos;
    in_dst_width  = r.dst_width;
    in_dst_height = r.dst_height;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_request(r);
    sent++;
  endtask

  initial begin : write_sink
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_beats % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      if (sink_beats == HOLD_AT_BEAT) hold = HOLD_CYCLES;
      else if (sink_quiet) hold = 0;
      else hold = $urandom_range(0, 18);
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      board.check_write(out_target, out_value, out_last);
      sink_beats++;
    end
  end

  initial begin : request_source
    int sw, sh, dw, dh, mode;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_src_width  = '0;
    in_src_height = '0;
    in_dst_xpos   = '0;
    in_dst_ypos   = '0;
    in_dst_width  = '0;
    in_dst_height = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(1, 1, 0, 0, 1, 1);
    send_request(4096, 4096, 4095, 4095, 4096, 4096);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(8191, 8191, 4095, 0, 8191, 8191);
    send_request(4097, 1, 0, 4095, 1, 4097);
    send_request(1, 1, 2730, 1365, 4096, 4096);
    send_request(4096, 4096, 1365, 2730, 1, 1);
    send_request(9, 1, 10, 20, 10, 1);
    send_request(10, 1, 30, 40, 10, 1);
    send_request(11, 1, 50, 60, 10, 1);
    send_request(20, 1, 70, 80, 10, 1);
    send_request(21, 1, 90, 100, 10, 1);
    send_request(1, 1, 5, 5, 3, 3);
    send_request(1920, 1080, 0, 0, 1280, 720);
    send_request(720, 480, 100, 200, 1920, 1080);
    send_request(0, 4096, 4095, 4095, 4096, 0);
    send_request(5000, 3000, 2048, 1024, 2500, 6000);

    // mix full-range, typical, tiny and near-boundary area ratios
    repeat (RANDOM_REQS) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          sw = $urandom_range(0, 8191);
          sh = $urandom_range(0, 8191);
          dw = $urandom_range(0, 8191);
          dh = $urandom_range(0, 8191);
        end
        1, 2, 3: begin
          sw = $urandom_range(1, 4096);
          sh = $urandom_range(1, 4096);
          dw = $urandom_range(1, 4096);
          dh = $urandom_range(1, 4096);
        end
        4, 5: begin
          sw = $urandom_range(1, 64);
          sh = $urandom_range(1, 64);
          dw = $urandom_range(1, 64);
          dh = $urandom_range(1, 64);
        end
        6, 7: begin
          dw = $urandom_range(1, 4096);
          dh = $urandom_range(1, 64);
          sh = dh;
          sw = dw + $urandom_range(0, 2) - 1;
        end
        default: begin
          dw = $urandom_range(1, 2048);
          dh = $urandom_range(1, 64);
          sh = dh;
          sw = 2 * dw + $urandom_range(0, 2) - 1;
        end
      endcase
      send_request(sw, sh, $urandom_range(0, 4095), $urandom_range(0, 4095), dw, dh);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_writes.size() != 0)
      board.report($sformatf("%0d writes never arrived", board.pending_writes.size()));

    $display("summary: %0d scaling requests, %0d scaler writes checked, %0d mismatches",
             board.requests, board.writes_checked, board.errors);
    $display("summary: zero, oversized and extreme sizes, all three filter sets, long output hold");
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
